FILE: sv/wtosc_pkg.sv
// ----------------------------------------------------------------------------
// wtosc_pkg
// Shared types and constants for the wavetable oscillator.
// ----------------------------------------------------------------------------
package wtosc_pkg;

  localparam int PHASE_W    = 43;
  localparam int FRAC_BITS  = 32;
  localparam int IDX_W      = 11;
  localparam int LEN_W      = 12;
  localparam int SAMPLE_W   = 16;
  localparam int BLEND_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 43;
  localparam int KIND_W     = 2;

  localparam logic [KIND_W-1:0] KIND_WRITE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PHASE_CLR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH = 1'd1;

  localparam logic [LEN_W-1:0] CYCLE_LENGTH_RST = 12'd2048;

  // shift of the reciprocal used to reduce a table address modulo the table depth
  localparam int RED_SHIFT = 24;

  typedef struct packed {
    logic                is_tick;
    logic                is_write;
    logic [IDX_W-1:0]    addr0;
    logic [IDX_W-1:0]    addr1;
    logic [IDX_W-1:0]    quo0;
    logic [IDX_W-1:0]    quo1;
    logic [BLEND_W-1:0]  frac;
    logic [SAMPLE_W-1:0] wdata;
  } req_t;

  typedef struct packed {
    logic [BLEND_W-1:0]  frac;
    logic [SAMPLE_W-1:0] s0;
    logic [SAMPLE_W-1:0] s1;
  } rd_t;

endpackage

FILE: sv/wtosc_in_if.sv
// ----------------------------------------------------------------------------
// wtosc_in_if
// Input channel: table writes, ticks and phase clears.
// ----------------------------------------------------------------------------
interface wtosc_in_if import wtosc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [IDX_W-1:0]    sample_addr;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, kind, sample_addr, sample_value, input ready);
  modport sink   (input valid, kind, sample_addr, sample_value, output ready);
endinterface

FILE: sv/wtosc_out_if.sv
// ----------------------------------------------------------------------------
// wtosc_out_if
// Output channel: interpolated samples.
// ----------------------------------------------------------------------------
interface wtosc_out_if import wtosc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

FILE: sv/wavetable_oscillator_lerp.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_lerp
// Wavetable oscillator with linear interpolation between adjacent samples.
//
//   channel  dir  payload                               transfer
//   in       in   kind, sample_addr, sample_value       valid && ready
//   out      out  sample_out (ticks only)               valid && ready
//   cfg      in   cfg_wr_index, cfg_wr_data             cfg_wr_en
//
// One item per cycle while the output is not stalled; a tick's sample passes
// through the request stage, table read, multiply and output register.
// The dual-read table sets the rate: both samples are read in the same cycle.
// Reset clears the pipeline valids, the phase and the configuration
// registers; the table is not cleared. A stalled output backs up three
// internal stages before in.ready drops.
// ----------------------------------------------------------------------------
module wavetable_oscillator_lerp import wtosc_pkg::*; #(
  parameter int TABLE_DEPTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  wtosc_in_if.sink              in,
  wtosc_out_if.source           out
);

  logic req_valid;
  req_t req;
  logic rd_valid;
  rd_t  rd;
  logic take;
  logic adv;

  assign adv      = !rd_valid || take;
  assign in.ready = !req_valid || adv;

  wtosc_phase #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_phase (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in.valid),
    .in_ready     (in.ready),
    .kind         (in.kind),
    .sample_addr  (in.sample_addr),
    .sample_value (in.sample_value),
    .req_valid    (req_valid),
    .req          (req)
  );

  wtosc_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req),
    .rd_valid  (rd_valid),
    .rd        (rd)
  );

  wtosc_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .rd_valid   (rd_valid),
    .rd         (rd),
    .take       (take),
    .out_ready  (out.ready),
    .out_valid  (out.valid),
    .sample_out (out.sample_out)
  );

endmodule

FILE: sv/wtosc_phase.sv
// ----------------------------------------------------------------------------
// wtosc_phase
// Configuration registers, phase accumulator and request stage.
// ----------------------------------------------------------------------------
module wtosc_phase import wtosc_pkg::*; #(
  parameter int TABLE_DEPTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [KIND_W-1:0]     kind,
  input  logic [IDX_W-1:0]      sample_addr,
  input  logic [SAMPLE_W-1:0]   sample_value,
  output logic                  req_valid,
  output req_t                  req
);

  localparam logic [RED_SHIFT-1:0] RED_MUL = RED_SHIFT'((1 << RED_SHIFT) / TABLE_DEPTH);
  localparam int PROD_W = IDX_W + RED_SHIFT;
  localparam logic [PHASE_W:0] WRAP_RST = (PHASE_W+1)'(0) - {CYCLE_LENGTH_RST, 32'd0};

  logic [PHASE_W-1:0] phase_step;
  logic [LEN_W-1:0]   cycle_length;
  logic [PHASE_W:0]   step_wrap;
  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] phase_acc_next;

  logic [PHASE_W:0]   sum;
  logic [PHASE_W:0]   wrapped;
  logic [PHASE_W:0]   limit;
  logic [IDX_W-1:0]   idx;
  logic [LEN_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   nxt;
  logic [IDX_W-1:0]   a0;
  logic [PROD_W-1:0]  p0;
  logic [PROD_W-1:0]  p1;
  logic               accept;
  logic               is_tick;
  logic               is_write;

  assign accept   = in_valid && in_ready;
  assign is_tick  = (kind == KIND_TICK);
  assign is_write = (kind == KIND_WRITE);

  always_comb begin
    sum     = {1'b0, phase_acc} + {1'b0, phase_step};
    wrapped = {1'b0, phase_acc} + step_wrap;
    limit   = {cycle_length, 32'd0};
    phase_acc_next = (sum >= limit) ? wrapped[PHASE_W-1:0] : sum[PHASE_W-1:0];
    idx     = phase_acc[PHASE_W-1:FRAC_BITS];
    idx_inc = {1'b0, idx} + 12'd1;
    nxt     = (idx_inc >= cycle_length) ? '0 : idx_inc[IDX_W-1:0];
    a0      = is_write ? sample_addr : idx;
    p0      = {{RED_SHIFT{1'b0}}, a0} * {{IDX_W{1'b0}}, RED_MUL};
    p1      = {{RED_SHIFT{1'b0}}, nxt} * {{IDX_W{1'b0}}, RED_MUL};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      cycle_length <= CYCLE_LENGTH_RST;
      step_wrap    <= WRAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_wr_index)
        REG_PHASE_STEP: begin
          phase_step <= cfg_wr_data;
          step_wrap  <= {1'b0, cfg_wr_data} - {cycle_length, 32'd0};
        end
        REG_CYCLE_LENGTH: begin
          cycle_length <= cfg_wr_data[LEN_W-1:0];
          step_wrap    <= {1'b0, phase_step} - {cfg_wr_data[LEN_W-1:0], 32'd0};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (accept) begin
      if (is_tick) begin
        phase_acc <= phase_acc_next;
      end else if (kind == KIND_PHASE_CLR) begin
        phase_acc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= accept && (is_tick || is_write);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.is_tick  <= is_tick;
      req.is_write <= is_write;
      req.addr0    <= a0;
      req.addr1    <= nxt;
      req.quo0     <= p0[PROD_W-1:RED_SHIFT];
      req.quo1     <= p1[PROD_W-1:RED_SHIFT];
      req.frac     <= phase_acc[FRAC_BITS-1:FRAC_BITS-BLEND_W];
      req.wdata    <= sample_value;
    end
  end

endmodule

FILE: sv/wtosc_table.sv
// ----------------------------------------------------------------------------
// wtosc_table
// Sample memory: address reduction, one write port, two registered reads.
// ----------------------------------------------------------------------------
module wtosc_table import wtosc_pkg::*; #(
  parameter int TABLE_DEPTH = 2048
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic req_valid,
  input  req_t req,
  output logic rd_valid,
  output rd_t  rd
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int QW  = IDX_W + 17;
  localparam int EXW = 17;

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];

  logic [QW-1:0]    qd0;
  logic [QW-1:0]    qd1;
  logic [IDX_W-1:0] r0;
  logic [IDX_W-1:0] r1;
  logic [EXW-1:0]   m0;
  logic [EXW-1:0]   m1;
  logic [AW-1:0]    ra0;
  logic [AW-1:0]    ra1;

  always_comb begin
    qd0 = {17'd0, req.quo0} * QW'(TABLE_DEPTH);
    qd1 = {17'd0, req.quo1} * QW'(TABLE_DEPTH);
    r0  = req.addr0 - qd0[IDX_W-1:0];
    r1  = req.addr1 - qd1[IDX_W-1:0];
    m0  = {{(EXW-IDX_W){1'b0}}, r0};
    m1  = {{(EXW-IDX_W){1'b0}}, r1};
    if (m0 >= EXW'(TABLE_DEPTH)) begin
      m0 = m0 - EXW'(TABLE_DEPTH);
    end
    if (m1 >= EXW'(TABLE_DEPTH)) begin
      m1 = m1 - EXW'(TABLE_DEPTH);
    end
    ra0 = m0[AW-1:0];
    ra1 = m1[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (req_valid && req.is_write) begin
        mem[ra0] <= req.wdata;
      end
      rd.s0   <= mem[ra0];
      rd.s1   <= mem[ra1];
      rd.frac <= req.frac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (adv) begin
      rd_valid <= req_valid && req.is_tick;
    end
  end

endmodule

FILE: sv/wtosc_blend.sv
// ----------------------------------------------------------------------------
// wtosc_blend
// Linear interpolation: multiply stage, then add into the output register.
// ----------------------------------------------------------------------------
module wtosc_blend import wtosc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_valid,
  input  rd_t                 rd,
  output logic                take,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] sample_out
);

  logic                m_valid;
  logic [SAMPLE_W-1:0] m_base;
  logic [31:0]         m_prod;
  logic [31:0]         diff;
  logic [47:0]         prod_full;
  logic                out_en;

  assign out_en = !out_valid || out_ready;
  assign take   = !m_valid || out_en;

  always_comb begin
    diff      = {16'd0, rd.s1} - {16'd0, rd.s0};
    prod_full = {16'd0, diff} * {32'd0, rd.frac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        m_valid <= rd_valid;
      end
      if (out_en) begin
        out_valid <= m_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_base <= rd.s0;
      m_prod <= prod_full[31:0];
    end
    if (out_en) begin
      sample_out <= m_base + m_prod[31:16];
    end
  end

endmodule
